// ----- hw/rtl/crntp_pkg.sv -----
// Shared types and constants for the cone-range nearest target picker.
package crntp_pkg;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_PROBE = 1'b1;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_DEGENERATE = 3'd1;
   localparam logic [2:0] STATUS_NO_CAND    = 3'd2;
   localparam logic [2:0] STATUS_RANGE      = 3'd3;
   localparam logic [2:0] STATUS_BAND       = 3'd4;
   localparam logic [2:0] STATUS_FACING     = 3'd5;

   localparam logic [2:0] STAGE_NONE    = 3'd0;
   localparam logic [2:0] STAGE_ENABLED = 3'd1;
   localparam logic [2:0] STAGE_RANGE   = 3'd2;
   localparam logic [2:0] STAGE_BAND    = 3'd3;
   localparam logic [2:0] STAGE_WINNER  = 3'd4;

   localparam logic [1:0] CSR_MAX_DISTANCE = 2'd0;
   localparam logic [1:0] CSR_MAX_VERTICAL = 2'd1;
   localparam logic [1:0] CSR_MIN_DOT      = 2'd2;
   localparam logic [1:0] CSR_DEGEN_LEN    = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FSQ_X, ST_FSQ_Z, ST_DEGEN,
      ST_DXX, ST_DZZ, ST_RR, ST_FXDX, ST_FZDZ, ST_MM, ST_MF,
      ST_LHH, ST_LHL, ST_LLL, ST_R00, ST_R01, ST_R10, ST_R11,
      ST_JUDGE, ST_END
   } state_type;

   typedef enum logic [4:0] {
      STEP_NONE, STEP_FSQ_X, STEP_FSQ_Z, STEP_DXX, STEP_DZZ, STEP_RR,
      STEP_FXDX, STEP_FZDZ, STEP_MM, STEP_MF, STEP_LHH, STEP_LHL, STEP_LLL,
      STEP_R00, STEP_R01, STEP_R10, STEP_R11
   } step_type;

   typedef struct packed {
      step_type step;
      logic     set_degen;
      logic     judge;
      logic     finish;
   } cmd_type;

   typedef struct packed {
      logic judge_now;
      logic last;
      logic out_free;
   } sts_type;

   function automatic logic [24:0] abs25(input logic signed [24:0] v);
      abs25 = v[24] ? 25'(-v) : 25'(v);
   endfunction

endpackage

// ----- hw/rtl/crntp_ctrl.sv -----
// Sequencer that steps the shared multiplier through each request.
module crntp_ctrl
   import crntp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_type,
   input  sts_type sts,
   output logic    req_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      cmd.step      = STEP_NONE;
      cmd.set_degen = 1'b0;
      cmd.judge     = 1'b0;
      cmd.finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_type == REQ_START) begin
                  state_in = ST_FSQ_X;
               end else if (sts.judge_now) begin
                  state_in = ST_DXX;
               end else begin
                  state_in = ST_END;
               end
            end
         end
         ST_FSQ_X: begin cmd.step = STEP_FSQ_X; state_in = ST_FSQ_Z; end
         ST_FSQ_Z: begin cmd.step = STEP_FSQ_Z; state_in = ST_DEGEN; end
         ST_DEGEN: begin cmd.set_degen = 1'b1; state_in = ST_END; end
         ST_DXX:   begin cmd.step = STEP_DXX;  state_in = ST_DZZ; end
         ST_DZZ:   begin cmd.step = STEP_DZZ;  state_in = ST_RR; end
         ST_RR:    begin cmd.step = STEP_RR;   state_in = ST_FXDX; end
         ST_FXDX:  begin cmd.step = STEP_FXDX; state_in = ST_FZDZ; end
         ST_FZDZ:  begin cmd.step = STEP_FZDZ; state_in = ST_MM; end
         ST_MM:    begin cmd.step = STEP_MM;   state_in = ST_MF; end
         ST_MF:    begin cmd.step = STEP_MF;   state_in = ST_LHH; end
         ST_LHH:   begin cmd.step = STEP_LHH;  state_in = ST_LHL; end
         ST_LHL:   begin cmd.step = STEP_LHL;  state_in = ST_LLL; end
         ST_LLL:   begin cmd.step = STEP_LLL;  state_in = ST_R00; end
         ST_R00:   begin cmd.step = STEP_R00;  state_in = ST_R01; end
         ST_R01:   begin cmd.step = STEP_R01;  state_in = ST_R10; end
         ST_R10:   begin cmd.step = STEP_R10;  state_in = ST_R11; end
         ST_R11:   begin cmd.step = STEP_R11;  state_in = ST_JUDGE; end
         ST_JUDGE: begin cmd.judge = 1'b1;     state_in = ST_END; end
         ST_END: begin
            if (!sts.last) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/crntp_dp.sv -----
// Datapath: registers, shared 32x32 multiplier, probe judging and result register.
module crntp_dp
   import crntp_pkg::*;
#(
   parameter int MAX_PROBES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_accept,
   input  logic               req_type,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [23:0] req_pos_z,
   input  logic signed [15:0] req_forward_x,
   input  logic signed [15:0] req_forward_z,
   input  logic signed [23:0] req_probe_radius,
   input  logic               req_probe_enabled,
   input  logic               req_last_item,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [22:0]        csr_wdata,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [8:0]         rsp_best_index
);

   localparam int CW = $clog2(MAX_PROBES + 1);
   localparam int IW = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

   logic [22:0]        max_dist_ff, max_vert_ff;
   logic signed [15:0] min_dot_ff;
   logic [15:0]        deg_len_ff;

   logic signed [23:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [15:0] facing_x_ff, facing_z_ff;
   logic               degen_ff;
   logic [31:0]        fsq_ff;

   logic [2:0]         stage_ff;
   logic [IW-1:0]      win_idx_ff;
   logic [49:0]        win_dist_ff;
   logic [CW-1:0]      cnt_ff;

   logic signed [24:0] dx_ff, dy_ff, dz_ff, reach_ff;
   logic               en_ff, last_ff, judge_ff;
   logic [IW-1:0]      idx_ff;

   logic [49:0]        dist_ff, rsq_ff;
   logic signed [41:0] dot_ff;
   logic [30:0]        mm_ff;
   logic [61:0]        k_ff;
   logic [83:0]        lsq_ff;
   logic [111:0]       r_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [8:0]         rsp_idx_ff;

   logic [31:0]        op_a, op_b;
   logic [63:0]        prod;
   logic [15:0]        fxm, fzm, mam;
   logic [24:0]        dxm, dzm, dym;
   logic [41:0]        dotm;
   logic signed [41:0] dot_p;
   logic               dot_sgn;
   logic               count_ok;
   logic               in_range, in_band, in_cone, coinc;
   logic [111:0]       lhs_sq;
   logic [2:0]         level;
   logic [CW+8:0]      cnt_ext;
   logic [IW+8:0]      win_ext;

   assign fxm  = facing_x_ff[15] ? 16'(-facing_x_ff) : 16'(facing_x_ff);
   assign fzm  = facing_z_ff[15] ? 16'(-facing_z_ff) : 16'(facing_z_ff);
   assign mam  = min_dot_ff[15] ? 16'(-min_dot_ff) : 16'(min_dot_ff);
   assign dxm  = abs25(dx_ff);
   assign dym  = abs25(dy_ff);
   assign dzm  = abs25(dz_ff);
   assign dotm = dot_ff[41] ? 42'(-dot_ff) : 42'(dot_ff);

   always_comb begin
      op_a    = '0;
      op_b    = '0;
      dot_sgn = 1'b0;
      case (cmd.step)
         STEP_FSQ_X: begin op_a = 32'(fxm); op_b = 32'(fxm); end
         STEP_FSQ_Z: begin op_a = 32'(fzm); op_b = 32'(fzm); end
         STEP_DXX:   begin op_a = 32'(dxm); op_b = 32'(dxm); end
         STEP_DZZ:   begin op_a = 32'(dzm); op_b = 32'(dzm); end
         STEP_RR: begin
            op_a = 32'(reach_ff[24:0]);
            op_b = 32'(reach_ff[24:0]);
         end
         STEP_FXDX: begin
            op_a    = 32'(fxm);
            op_b    = 32'(dxm);
            dot_sgn = facing_x_ff[15] ^ dx_ff[24];
         end
         STEP_FZDZ: begin
            op_a    = 32'(fzm);
            op_b    = 32'(dzm);
            dot_sgn = facing_z_ff[15] ^ dz_ff[24];
         end
         STEP_MM:  begin op_a = 32'(mam); op_b = 32'(mam); end
         STEP_MF:  begin op_a = 32'(mm_ff); op_b = fsq_ff; end
         STEP_LHH: begin op_a = 32'(dotm[41:21]); op_b = 32'(dotm[41:21]); end
         STEP_LHL: begin op_a = 32'(dotm[41:21]); op_b = 32'(dotm[20:0]); end
         STEP_LLL: begin op_a = 32'(dotm[20:0]); op_b = 32'(dotm[20:0]); end
         STEP_R00: begin op_a = k_ff[31:0]; op_b = dist_ff[31:0]; end
         STEP_R01: begin op_a = k_ff[31:0]; op_b = 32'(dist_ff[49:32]); end
         STEP_R10: begin op_a = 32'(k_ff[61:32]); op_b = dist_ff[31:0]; end
         STEP_R11: begin op_a = 32'(k_ff[61:32]); op_b = 32'(dist_ff[49:32]); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod  = op_a * op_b;
   assign dot_p = dot_sgn ? -$signed({1'b0, prod[40:0]}) : $signed({1'b0, prod[40:0]});

   assign count_ok = cnt_ff < CW'(MAX_PROBES);
   assign lhs_sq   = {lsq_ff, 28'b0};
   assign in_range = !reach_ff[24] && (dist_ff <= rsq_ff);
   assign in_band  = dym <= {2'b0, max_vert_ff};
   assign coinc    = dist_ff <= {34'b0, deg_len_ff};

   always_comb begin
      if (coinc) begin
         in_cone = 1'b1;
      end else if (!dot_ff[41] && (min_dot_ff <= 0)) begin
         in_cone = 1'b1;
      end else if (dot_ff[41] && !min_dot_ff[15]) begin
         in_cone = 1'b0;
      end else if (!dot_ff[41]) begin
         in_cone = lhs_sq >= r_ff;
      end else begin
         in_cone = lhs_sq <= r_ff;
      end
      if (in_range && in_band && in_cone) begin
         level = STAGE_WINNER;
      end else if (in_range && in_band) begin
         level = STAGE_BAND;
      end else if (in_range) begin
         level = STAGE_RANGE;
      end else begin
         level = STAGE_ENABLED;
      end
   end

   assign cnt_ext = {9'b0, cnt_ff};
   assign win_ext = {9'b0, win_idx_ff};

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= 23'd512;
         max_vert_ff <= 23'd256;
         min_dot_ff  <= 16'sd11585;
         deg_len_ff  <= 16'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_DISTANCE: max_dist_ff <= csr_wdata;
            CSR_MAX_VERTICAL: max_vert_ff <= csr_wdata;
            CSR_MIN_DOT:      min_dot_ff  <= csr_wdata[15:0];
            CSR_DEGEN_LEN:    deg_len_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // observer and set state
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         facing_x_ff  <= '0;
         facing_z_ff  <= '0;
         degen_ff     <= 1'b1;
         stage_ff     <= STAGE_NONE;
         win_idx_ff   <= '0;
         win_dist_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept && req_type == REQ_START) begin
            origin_x_ff <= req_pos_x;
            origin_y_ff <= req_pos_y;
            origin_z_ff <= req_pos_z;
            facing_x_ff <= req_forward_x;
            facing_z_ff <= req_forward_z;
            stage_ff    <= STAGE_NONE;
            win_idx_ff  <= '0;
            win_dist_ff <= '0;
            cnt_ff      <= '0;
         end else if (req_accept && count_ok) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.set_degen) begin
            degen_ff <= fsq_ff <= {16'b0, deg_len_ff};
         end
         if (cmd.judge && judge_ff && en_ff) begin
            if (level == STAGE_WINNER) begin
               if (stage_ff != STAGE_WINNER || dist_ff < win_dist_ff) begin
                  win_idx_ff  <= idx_ff;
                  win_dist_ff <= dist_ff;
               end
               stage_ff <= STAGE_WINNER;
            end else if (level > stage_ff) begin
               stage_ff <= level;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            stage_ff     <= STAGE_NONE;
            win_idx_ff   <= '0;
            win_dist_ff  <= '0;
            cnt_ff       <= '0;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture, multiplier accumulation and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         last_ff  <= req_last_item;
         en_ff    <= req_probe_enabled;
         idx_ff   <= cnt_ff[IW-1:0];
         judge_ff <= count_ok && !degen_ff;
         dx_ff    <= $signed({req_pos_x[23], req_pos_x}) - $signed({origin_x_ff[23], origin_x_ff});
         dy_ff    <= $signed({req_pos_y[23], req_pos_y}) - $signed({origin_y_ff[23], origin_y_ff});
         dz_ff    <= $signed({req_pos_z[23], req_pos_z}) - $signed({origin_z_ff[23], origin_z_ff});
         reach_ff <= $signed({2'b0, max_dist_ff})
                     + $signed({req_probe_radius[23], req_probe_radius});
      end
      case (cmd.step)
         STEP_FSQ_X: fsq_ff  <= prod[31:0];
         STEP_FSQ_Z: fsq_ff  <= fsq_ff + prod[31:0];
         STEP_DXX:   dist_ff <= prod[49:0];
         STEP_DZZ:   dist_ff <= dist_ff + prod[49:0];
         STEP_RR:    rsq_ff  <= prod[49:0];
         STEP_FXDX:  dot_ff  <= dot_p;
         STEP_FZDZ:  dot_ff  <= dot_ff + dot_p;
         STEP_MM:    mm_ff   <= prod[30:0];
         STEP_MF:    k_ff    <= prod[61:0];
         STEP_LHH:   lsq_ff  <= {prod[41:0], 42'b0};
         STEP_LHL:   lsq_ff  <= lsq_ff + ({20'b0, prod} << 22);
         STEP_LLL:   lsq_ff  <= lsq_ff + {20'b0, prod};
         STEP_R00:   r_ff    <= {48'b0, prod};
         STEP_R01:   r_ff    <= r_ff + ({48'b0, prod} << 32);
         STEP_R10:   r_ff    <= r_ff + ({48'b0, prod} << 32);
         STEP_R11:   r_ff    <= r_ff + ({48'b0, prod} << 64);
         default: ;
      endcase
      if (cmd.finish) begin
         rsp_idx_ff <= cnt_ext[8:0];
         if (degen_ff) begin
            rsp_status_ff <= STATUS_DEGENERATE;
         end else begin
            case (stage_ff)
               STAGE_WINNER: begin
                  rsp_status_ff <= STATUS_OK;
                  rsp_idx_ff    <= win_ext[8:0];
               end
               STAGE_ENABLED: rsp_status_ff <= STATUS_RANGE;
               STAGE_RANGE:   rsp_status_ff <= STATUS_BAND;
               STAGE_BAND:    rsp_status_ff <= STATUS_FACING;
               default:       rsp_status_ff <= STATUS_NO_CAND;
            endcase
         end
      end
   end

   assign sts.judge_now = count_ok && !degen_ff;
   assign sts.last      = last_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_best_index = rsp_idx_ff;

endmodule

// ----- hw/rtl/cone_range_nearest_target_picker.sv -----
// Top level of the cone-range nearest target picker.
//
// Request channel (req_valid/req_stall): a start request sets the observer
// position and XZ forward and opens a set; each probe request is one candidate
// with a running index. A request with req_last_item set closes the set and
// produces one result on the rsp channel: status and best index.
// CSR channel (csr_valid/csr_ready, csr_index, csr_wdata): csr_ready is always
// high; write only while the block is idle.
// Timing: one request at a time through a single shared 32x32 multiplier.
// A judged probe runs its multiply steps, then judge and end; a start squares
// the forward; a skipped probe (degenerate forward or past MAX_PROBES) ends.
// The result register is loaded in the end state of the last request, so
// rsp_valid rises in the cycle after that.
// Reset clears the set, the origin and forward, marks the forward degenerate
// and loads the CSR defaults. While rsp_stall holds a result, the block keeps
// taking requests and waits only when it has a new result to load.
module cone_range_nearest_target_picker
   import crntp_pkg::*;
#(
   parameter int MAX_PROBES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [23:0] req_pos_z,
   input  logic signed [15:0] req_forward_x,
   input  logic signed [15:0] req_forward_z,
   input  logic signed [23:0] req_probe_radius,
   input  logic               req_probe_enabled,
   input  logic               req_last_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [22:0]        csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [8:0]         rsp_best_index
);

   cmd_type cmd;
   sts_type sts;
   logic    req_accept;

   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   crntp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   crntp_dp #(
      .MAX_PROBES (MAX_PROBES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_accept        (req_accept),
      .req_type          (req_type),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_forward_x     (req_forward_x),
      .req_forward_z     (req_forward_z),
      .req_probe_radius  (req_probe_radius),
      .req_probe_enabled (req_probe_enabled),
      .req_last_item     (req_last_item),
      .cmd               (cmd),
      .sts               (sts),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_best_index    (rsp_best_index)
   );

endmodule

// ----- hw/rtl/crntp_checker.sv -----
// Port-level assertions for the cone-range nearest target picker, with bind.
module crntp_checker
   import crntp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [8:0] rsp_best_index
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_FACING))
      else $error("status code out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_best_index)))
      else $error("stalled result changed");

endmodule

bind cone_range_nearest_target_picker crntp_checker u_crntp_checker (.*);

// ----- tb/sv/tb.sv -----
// Testbench for the cone-range nearest target picker: random stimulus, self-checking predictor.
`timescale 1ns / 1ps
module tb;
   import crntp_pkg::*;

   localparam int PROBE_LIMIT = 256;
   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic               kind;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic signed [15:0] fx;
      logic signed [15:0] fz;
      logic signed [23:0] radius;
      logic               enabled;
      logic               last;
   } probe_req_type;

   typedef struct {
      logic [2:0] status;
      logic [8:0] index;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = REQ_START;
   logic signed [23:0] req_pos_x = '0;
   logic signed [23:0] req_pos_y = '0;
   logic signed [23:0] req_pos_z = '0;
   logic signed [15:0] req_forward_x = '0;
   logic signed [15:0] req_forward_z = '0;
   logic signed [23:0] req_probe_radius = '0;
   logic req_probe_enabled = 1'b0;
   logic req_last_item = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_MAX_DISTANCE;
   logic [22:0] csr_wdata = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [8:0] rsp_best_index;

   verdict_type verdicts_due[$];
   int mismatches = 0;
   int hold_cycles = 0;
   int stall_burst = 0;
   bit quiet = 0;
   int quiet_cycles = 0;

   // picker state
   logic [22:0] cfg_max_dist;
   logic [22:0] cfg_max_vert;
   logic signed [15:0] cfg_min_dot;
   logic [15:0] cfg_degen;
   longint org_x, org_y, org_z, face_x, face_z;
   bit face_degen;
   logic [2:0] stage;
   int win_index;
   longint win_dist;
   int probe_count;

   cone_range_nearest_target_picker dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void picker_reset();
      cfg_max_dist = 23'd512;
      cfg_max_vert = 23'd256;
      cfg_min_dot = 16'sd11585;
      cfg_degen = 16'd1;
      org_x = 0; org_y = 0; org_z = 0; face_x = 0; face_z = 0;
      face_degen = 1;
      stage = STAGE_NONE; win_index = 0; win_dist = 0; probe_count = 0;
   endfunction

   function automatic bit facing_ok(input longint dx, input longint dz, input longint dsq);
      longint lhs, m, al, am, fsq;
      logic [127:0] la, ma, fq, dq, lsq, rsq;
      if (dsq <= longint'(cfg_degen)) return 1;
      m = cfg_min_dot;
      lhs = (face_x * dx + face_z * dz) * 16384;
      if (lhs >= 0 && m <= 0) return 1;
      if (lhs < 0 && m >= 0) return 0;
      al = lhs < 0 ? -lhs : lhs;
      am = m < 0 ? -m : m;
      fsq = face_x * face_x + face_z * face_z;
      la = al; ma = am; fq = fsq; dq = dsq;
      lsq = la * la;
      rsq = ma * ma * fq * dq;
      return lhs >= 0 ? (lsq >= rsq) : (lsq <= rsq);
   endfunction

   function automatic void judge(input probe_req_type r, input int idx);
      longint dx, dy, dz, dsq, reach, ady;
      if (!r.enabled) return;
      if (stage < STAGE_ENABLED) stage = STAGE_ENABLED;
      dx = longint'(r.x) - org_x;
      dy = longint'(r.y) - org_y;
      dz = longint'(r.z) - org_z;
      dsq = dx * dx + dz * dz;
      reach = longint'(cfg_max_dist) + longint'(r.radius);
      if (reach < 0 || dsq > reach * reach) return;
      if (stage < STAGE_RANGE) stage = STAGE_RANGE;
      ady = dy < 0 ? -dy : dy;
      if (ady > longint'(cfg_max_vert)) return;
      if (stage < STAGE_BAND) stage = STAGE_BAND;
      if (!facing_ok(dx, dz, dsq)) return;
      if (stage < STAGE_WINNER || dsq < win_dist) begin
         win_index = idx;
         win_dist = dsq;
      end
      stage = STAGE_WINNER;
   endfunction

   function automatic void picker_step(input probe_req_type r);
      verdict_type v;
      if (r.kind == REQ_START) begin
         org_x = r.x; org_y = r.y; org_z = r.z;
         face_x = r.fx; face_z = r.fz;
         face_degen = (face_x * face_x + face_z * face_z) <= longint'(cfg_degen);
         stage = STAGE_NONE; win_index = 0; win_dist = 0; probe_count = 0;
      end else if (probe_count < PROBE_LIMIT) begin
         probe_count++;
         if (!face_degen) judge(r, probe_count - 1);
      end
      if (!r.last) return;
      v.index = 9'(probe_count);
      if (face_degen) v.status = STATUS_DEGENERATE;
      else if (stage == STAGE_WINNER) begin
         v.status = STATUS_OK;
         v.index = 9'(win_index);
      end else if (stage == STAGE_ENABLED) v.status = STATUS_RANGE;
      else if (stage == STAGE_RANGE) v.status = STATUS_BAND;
      else if (stage == STAGE_BAND) v.status = STATUS_FACING;
      else v.status = STATUS_NO_CAND;
      verdicts_due.push_back(v);
      stage = STAGE_NONE; win_index = 0; win_dist = 0; probe_count = 0;
   endfunction

   task automatic send_request(input probe_req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_pos_x <= r.x;
      req_pos_y <= r.y;
      req_pos_z <= r.z;
      req_forward_x <= r.fx;
      req_forward_z <= r.fz;
      req_probe_radius <= r.radius;
      req_probe_enabled <= r.enabled;
      req_last_item <= r.last;
      do @(posedge clock); while (req_stall);
      picker_step(r);
   endtask

   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [22:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MAX_DISTANCE: cfg_max_dist = data;
         CSR_MAX_VERTICAL: cfg_max_vert = data;
         CSR_MIN_DOT:      cfg_min_dot = data[15:0];
         default:          cfg_degen = data[15:0];
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic configure(input int md, input int mv, input int dot, input int dg);
      wait_idle();
      write_csr(CSR_MAX_DISTANCE, 23'(md));
      write_csr(CSR_MAX_VERTICAL, 23'(mv));
      write_csr(CSR_MIN_DOT, 23'(dot & 16'hFFFF));
      write_csr(CSR_DEGEN_LEN, 23'(dg));
   endtask

   function automatic probe_req_type make_req(input logic kind, input longint x, input longint y,
                                              input longint z, input longint fx, input longint fz,
                                              input longint rad, input logic en, input logic last);
      probe_req_type r;
      r.kind = kind; r.x = 24'(x); r.y = 24'(y); r.z = 24'(z); r.fx = 16'(fx); r.fz = 16'(fz);
      r.radius = 24'(rad); r.enabled = en; r.last = last;
      return r;
   endfunction

   function automatic longint clamp24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint near(input longint base, input int span);
      return clamp24(base + longint'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic probe_req_type random_probe(input int span, input int vspan,
                                                  input logic last);
      probe_req_type r;
      r = make_req(REQ_PROBE, near(org_x, span), near(org_y, vspan), near(org_z, span),
                   $urandom, $urandom, near(0, span / 4 + 1), $urandom_range(0, 7) != 0, last);
      if ($urandom_range(0, 15) == 0) begin
         r.x = 24'($urandom); r.y = 24'($urandom); r.z = 24'($urandom);
         r.radius = 24'($urandom);
      end
      return r;
   endfunction

   task automatic run_sets(input int count, input int span, input int vspan);
      int sent, n;
      probe_req_type r;
      sent = 0;
      while (sent < count) begin
         r = make_req(REQ_START, near(0, 4000000), near(0, 4000000), near(0, 4000000),
                      $urandom, $urandom, $urandom, 1'($urandom), 1'b0);
         if ($urandom_range(0, 9) == 0) begin
            r.fx = 16'($urandom_range(0, 2)); r.fz = 16'($urandom_range(0, 2));
         end
         r.last = $urandom_range(0, 19) == 0;
         send_request(r);
         sent++;
         if (r.last) continue;
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) begin
            send_request(random_probe(span, vspan, i == n - 1));
            sent++;
         end
      end
   endtask

   task automatic test_reset_state();
      send_request(make_req(REQ_PROBE, 100, 0, 0, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 0, 0, 0, 0, 0, 0, 1, 1));
      send_request(make_req(REQ_START, 0, 0, 0, 16384, 0, 0, 0, 1));
   endtask

   task automatic test_directed();
      send_request(make_req(REQ_START, 0, 0, 0, 16384, 0, 0, 0, 0));
      send_request(make_req(REQ_PROBE, 300, 0, 0, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 200, 0, 0, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 0, 0, 200, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, -200, 0, 0, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 200, 300, 0, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 2000, 0, 0, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 2000, 0, 0, 0, 0, 1600, 1, 0));
      send_request(make_req(REQ_PROBE, 100, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(REQ_PROBE, 0, 0, 0, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 0, 0, 1, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 10, 0, 0, 0, 0, -8388608, 1, 0));
      send_request(make_req(REQ_PROBE, 0, 0, 0, 0, 0, 0, 1, 1));
      send_request(make_req(REQ_START, -8388608, 8388607, -8388608, -32768, 32767, 0, 0, 0));
      send_request(make_req(REQ_PROBE, 8388607, -8388608, 8388607, 0, 0, 8388607, 1, 1));
      send_request(make_req(REQ_START, 5, 5, 5, 1, 0, 0, 0, 0));
      send_request(make_req(REQ_PROBE, 5, 5, 5, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_PROBE, 50, 5, 5, 0, 0, 0, 1, 1));
      send_request(make_req(REQ_START, 0, 0, 0, 0, -16384, 0, 0, 1));
      send_request(make_req(REQ_START, 0, 0, 0, 32767, -32768, 0, 0, 1));
      send_request(make_req(REQ_START, 0, 0, 0, 0, 16384, 0, 0, 0));
      send_request(make_req(REQ_PROBE, 0, 0, 100, 0, 0, 0, 0, 1));
   endtask

   task automatic test_config_sweep();
      configure(0, 0, 0, 0);
      run_sets(50, 8, 4);
      configure(8388607, 8388607, -16384, 65535);
      run_sets(50, 4000000, 4000000);
      configure(4000, 300, 16384, 65535);
      run_sets(50, 8000, 600);
      configure(20000, 8388607, -5000, 100);
      run_sets(50, 40000, 1000);
      configure(1000, 50, 0, 1);
      run_sets(50, 2000, 100);
      configure(512, 256, 11585, 1);
      run_sets(50, 1024, 512);
   endtask

   task automatic test_probe_overflow();
      send_request(make_req(REQ_START, 0, 0, 0, 16384, 0, 0, 0, 0));
      for (int i = 0; i < 258; i++) send_request(random_probe(1024, 512, i == 257));
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_cycles = 300;
      run_sets(40, 1024, 512);
      wait_idle();
      run_sets(20, 1024, 512);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      run_sets(250, 1024, 512);
      quiet = 1;
      run_sets(120, 1024, 512);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) report_mismatch("result with none expected");
         else begin
            verdict_type v;
            v = verdicts_due.pop_front();
            if (rsp_status !== v.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, v.status));
            if (rsp_best_index !== v.index)
               report_mismatch($sformatf("best_index %0d, expected %0d", rsp_best_index,
                                         v.index));
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (stall_burst > 0) begin
         rsp_stall <= 1'b1;
         stall_burst--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_burst = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      picker_reset();
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_reset_state();
      test_directed();
      test_config_sweep();
      test_probe_overflow();
      test_backpressure();
      test_random_traffic();
      @(negedge clock) req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
